@@ hdl/msfd_pkg.sv @@
// Shared types and constants for the magic sync frame deframer.
// Used by msfd_out_skid and the top level; no dependencies of its own.
package msfd_pkg;

    localparam int HDR_BYTES = 13;
    localparam int FILL_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] MAGIC_RESET   = 32'd0;
    localparam logic [31:0] MAX_LEN_RESET = 32'd4096;
    localparam logic [7:0]  MAX_KIND_RESET = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC    = 2'd0,
        CFG_MAX_LEN  = 2'd1,
        CFG_MAX_KIND = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic        is_header;
        logic [7:0]  frame_kind;
        logic [31:0] frame_channel;
        logic [31:0] frame_length;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
    } result_t;

endpackage

@@ hdl/msfd_cell.sv @@
// One byte cell of the header window chain.
// Depends on nothing; instantiated by magic_sync_frame_deframer_top.
module msfd_cell
(
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] data_in,
    output logic [7:0] data_out
);

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out = data_reg;

endmodule

@@ hdl/msfd_out_skid.sv @@
// Result register with a skid entry behind it.
// Depends on msfd_pkg (result_t).
module msfd_out_skid
    import msfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t out_data,
    output logic    full
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

@@ hdl/magic_sync_frame_deframer_top.sv @@
// Top level of the magic sync frame deframer: byte cell chain, header check,
// payload counter, configuration registers. Depends on msfd_pkg, msfd_cell,
// msfd_out_skid.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    rx_byte
//   out      out_valid / out_stall  is_header, frame_kind, frame_channel,
//                                   frame_length, payload_byte, last_of_frame
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte beat per cycle while in_stall is low; each result is registered.
// The 13-byte window check runs in the same cycle as the byte shift.
// in_stall comes only from the registered skid entry, so input keeps
// flowing while one result waits. After reset the block is hunting with
// an empty window; cfg_ready is always high.
module magic_sync_frame_deframer_top
    import msfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 is_header,
    output logic [7:0]           frame_kind,
    output logic [31:0]          frame_channel,
    output logic [31:0]          frame_length,
    output logic [7:0]           payload_byte,
    output logic                 last_of_frame,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [31:0] magic_reg;
    logic [31:0] max_len_reg;
    logic [7:0]  max_kind_reg;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              in_payload_reg;
    logic              in_payload_next;
    logic [31:0]       remain_reg;
    logic [31:0]       remain_next;
    logic [7:0]        kind_reg;
    logic [7:0]        kind_next;
    logic [31:0]       chan_reg;
    logic [31:0]       chan_next;
    logic [31:0]       len_reg;
    logic [31:0]       len_next;

    logic [7:0]  win [HDR_BYTES];
    logic [7:0]  nwin [HDR_BYTES];
    logic        accept;
    logic        shift_en;
    logic        full_after;
    logic        hdr_ok;
    logic [31:0] hdr_magic;
    logic [31:0] hdr_len;
    logic [7:0]  hdr_kind;
    logic [31:0] hdr_chan;
    logic [31:0] remain_dec;
    logic        push;
    result_t     push_data;
    result_t     out_data;
    logic        skid_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_full;
    assign accept    = in_valid && !skid_full;
    assign shift_en  = accept && !in_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg    <= MAGIC_RESET;
            max_len_reg  <= MAX_LEN_RESET;
            max_kind_reg <= MAX_KIND_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAGIC:    magic_reg    <= cfg_data;
                CFG_MAX_LEN:  max_len_reg  <= cfg_data;
                CFG_MAX_KIND: max_kind_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    for (genvar i = 0; i < HDR_BYTES; i++)
    begin : g_cell
        if (i == HDR_BYTES - 1)
        begin : g_tail
            msfd_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .data_in  (rx_byte),
                .data_out (win[i])
            );
        end
        else
        begin : g_body
            msfd_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .data_in  (win[i+1]),
                .data_out (win[i])
            );
        end
    end

    always_comb
    begin
        for (int i = 0; i < HDR_BYTES - 1; i++)
        begin
            nwin[i] = win[i+1];
        end
        nwin[HDR_BYTES-1] = rx_byte;
    end

    assign hdr_magic  = {nwin[3], nwin[2], nwin[1], nwin[0]};
    assign hdr_len    = {nwin[7], nwin[6], nwin[5], nwin[4]};
    assign hdr_kind   = nwin[8];
    assign hdr_chan   = {nwin[12], nwin[11], nwin[10], nwin[9]};
    assign full_after = fill_reg >= FILL_W'(HDR_BYTES - 1);
    assign hdr_ok     = full_after && (hdr_magic == magic_reg)
                        && (hdr_len <= max_len_reg) && (hdr_kind <= max_kind_reg);
    assign remain_dec = remain_reg - 32'd1;

    always_comb
    begin
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        remain_next     = remain_reg;
        kind_next       = kind_reg;
        chan_next       = chan_reg;
        len_next        = len_reg;
        push            = 1'b0;
        push_data       = '0;
        if (accept)
        begin
            if (in_payload_reg)
            begin
                remain_next             = remain_dec;
                push                    = 1'b1;
                push_data.is_header     = 1'b0;
                push_data.frame_kind    = kind_reg;
                push_data.frame_channel = chan_reg;
                push_data.frame_length  = len_reg;
                push_data.payload_byte  = rx_byte;
                push_data.last_of_frame = (remain_dec == 32'd0);
                if (remain_dec == 32'd0)
                begin
                    in_payload_next = 1'b0;
                    fill_next       = '0;
                end
            end
            else if (hdr_ok)
            begin
                kind_next               = hdr_kind;
                chan_next               = hdr_chan;
                len_next                = hdr_len;
                remain_next             = hdr_len;
                fill_next               = '0;
                in_payload_next         = (hdr_len != 32'd0);
                push                    = 1'b1;
                push_data.is_header     = 1'b1;
                push_data.frame_kind    = hdr_kind;
                push_data.frame_channel = hdr_chan;
                push_data.frame_length  = hdr_len;
                push_data.payload_byte  = 8'd0;
                push_data.last_of_frame = (hdr_len == 32'd0);
            end
            else if (full_after)
            begin
                fill_next = FILL_W'(HDR_BYTES);
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            in_payload_reg <= 1'b0;
            remain_reg     <= '0;
            kind_reg       <= '0;
            chan_reg       <= '0;
            len_reg        <= '0;
        end
        else
        begin
            fill_reg       <= fill_next;
            in_payload_reg <= in_payload_next;
            remain_reg     <= remain_next;
            kind_reg       <= kind_next;
            chan_reg       <= chan_next;
            len_reg        <= len_next;
        end
    end

    msfd_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (skid_full)
    );

    assign is_header     = out_data.is_header;
    assign frame_kind    = out_data.frame_kind;
    assign frame_channel = out_data.frame_channel;
    assign frame_length  = out_data.frame_length;
    assign payload_byte  = out_data.payload_byte;
    assign last_of_frame = out_data.last_of_frame;

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for magic_sync_frame_deframer_top: directed byte table, then random
// frame streams under several register settings, checked against a built-in deframer.
// Depends on msfd_pkg and the hdl sources only.
module tb_top;
    import msfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE      = 4;
    localparam int LONG_HOLD   = 100;
    localparam int PHASE_BYTES = 185;
    localparam int NUM_PHASES  = 5;
    localparam int INTRO_ROWS  = 32;

    typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

    typedef enum int {FLAW_NONE, FLAW_MAGIC, FLAW_LENGTH, FLAW_KIND, FLAW_SHORT} flaw_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [31:0]             data;
        logic                    typed;
        result_t                 want;
    } intro_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 is_header;
    logic [7:0]           frame_kind;
    logic [31:0]          frame_channel;
    logic [31:0]          frame_length;
    logic [7:0]           payload_byte;
    logic                 last_of_frame;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = 32'h0;

    // deframer copy
    logic [7:0]  win_bytes [HDR_BYTES];
    int          win_count = 0;
    bit          in_frame = 1'b0;
    logic [31:0] left_in_frame = 32'h0;
    logic [7:0]  cur_kind = 8'h00;
    logic [31:0] cur_channel = 32'h0;
    logic [31:0] cur_length = 32'h0;
    logic [31:0] sync_word = MAGIC_RESET;
    logic [31:0] len_limit = MAX_LEN_RESET;
    logic [7:0]  kind_limit = MAX_KIND_RESET;

    result_t     due_results [$];
    logic        row_typed = 1'b0;
    result_t     row_want = '0;
    int          mismatches = 0;
    int          bytes_sent = 0;

    bit          calm = 1'b0;
    int          hold_req = 0;
    int          hold_taken = 0;
    int          stall_left = 0;
    int          run_left = 0;
    int          pick;

    logic [31:0] ph_magic;
    logic [31:0] ph_max_len;
    logic [7:0]  ph_max_kind;

    result_t     seen;
    result_t     oldest;
    result_t     predicted;
    bit          produced;

    intro_row_t intro_rows [INTRO_ROWS] = '{
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b1, '{1'b1, 8'h00, 32'h0, 32'h0, 8'h00, 1'b1}},
        '{ROW_REG, CFG_MAGIC, 32'h3CC35AA5, 1'b0, '0},
        '{ROW_REG, CFG_MAX_LEN, 32'h00000001, 1'b0, '0},
        '{ROW_REG, CFG_MAX_KIND, 32'hFFFFFF80, 1'b0, '0},
        '{ROW_REG, CFG_SPARE, 32'hFFFFFFFF, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'hA5, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h5A, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'hC3, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h3C, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h01, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h00, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'h80, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'hFF, 1'b0, '0},
        '{ROW_BYTE, CFG_MAGIC, 32'hFF, 1'b1,
          '{1'b1, 8'h80, 32'hFFFFFFFF, 32'h1, 8'h00, 1'b0}},
        '{ROW_BYTE, CFG_MAGIC, 32'hFF, 1'b1,
          '{1'b0, 8'h80, 32'hFFFFFFFF, 32'h1, 8'hFF, 1'b1}}
    };

    magic_sync_frame_deframer_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_header     (is_header),
        .frame_kind    (frame_kind),
        .frame_channel (frame_channel),
        .frame_length  (frame_length),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("** magic_sync_frame_deframer_top: FAILED **");
        $finish;
    end

    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        int          k;
        logic [31:0] len;
        r = '0;
        if (in_frame)
        begin
            if (left_in_frame != 0)
                left_in_frame = left_in_frame - 1;
            r.is_header     = 1'b0;
            r.frame_kind    = cur_kind;
            r.frame_channel = cur_channel;
            r.frame_length  = cur_length;
            r.payload_byte  = b;
            r.last_of_frame = (left_in_frame == 0);
            if (left_in_frame == 0)
            begin
                in_frame  = 1'b0;
                win_count = 0;
            end
            return 1'b1;
        end
        if (win_count >= HDR_BYTES)
        begin
            for (k = 0; k < HDR_BYTES - 1; k++)
                win_bytes[k] = win_bytes[k + 1];
            win_bytes[HDR_BYTES - 1] = b;
        end
        else
        begin
            win_bytes[win_count] = b;
            win_count++;
        end
        if (win_count < HDR_BYTES)
            return 1'b0;
        len = {win_bytes[7], win_bytes[6], win_bytes[5], win_bytes[4]};
        if ({win_bytes[3], win_bytes[2], win_bytes[1], win_bytes[0]} != sync_word
            || len > len_limit || win_bytes[8] > kind_limit)
            return 1'b0;
        cur_kind      = win_bytes[8];
        cur_channel   = {win_bytes[12], win_bytes[11], win_bytes[10], win_bytes[9]};
        cur_length    = len;
        left_in_frame = len;
        win_count     = 0;
        in_frame      = (len != 0);
        r.is_header     = 1'b1;
        r.frame_kind    = cur_kind;
        r.frame_channel = cur_channel;
        r.frame_length  = cur_length;
        r.payload_byte  = 8'h00;
        r.last_of_frame = (len == 0);
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want_v, got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %h got %h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen = {is_header, frame_kind, frame_channel, frame_length,
                        payload_byte, last_of_frame};
                if (due_results.size() == 0)
                begin
                    $display("%0t: result expected none got %h", $time, seen);
                    mismatches++;
                end
                else
                begin
                    oldest = due_results.pop_front();
                    check_field("is_header", 32'(oldest.is_header), 32'(seen.is_header));
                    check_field("frame_kind", 32'(oldest.frame_kind), 32'(seen.frame_kind));
                    check_field("frame_channel", oldest.frame_channel, seen.frame_channel);
                    check_field("frame_length", oldest.frame_length, seen.frame_length);
                    check_field("payload_byte", 32'(oldest.payload_byte),
                                32'(seen.payload_byte));
                    check_field("last_of_frame", 32'(oldest.last_of_frame),
                                32'(seen.last_of_frame));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAGIC:    sync_word = cfg_data;
                    CFG_MAX_LEN:  len_limit = cfg_data;
                    CFG_MAX_KIND: kind_limit = cfg_data[7:0];
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                produced = deframe_byte(rx_byte, predicted);
                if (row_typed)
                    due_results.push_back(row_want);
                else if (produced)
                    due_results.push_back(predicted);
            end
        end
    end

    // receiver stalls; a hold request forces one long hold-off
    always @(posedge clk)
    begin
        if (hold_taken != hold_req)
        begin
            hold_taken = hold_req;
            stall_left = LONG_HOLD;
            run_left   = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (run_left > 0 || calm)
        begin
            if (run_left > 0)
                run_left--;
            out_stall <= 1'b0;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                run_left = $urandom_range(1, 15);
                out_stall <= 1'b0;
            end
            else if (pick < 95)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = $urandom_range(10, 40);
                out_stall <= 1'b1;
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic typed, input result_t want);
        int gap;
        gap = 0;
        if (!calm)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 95)
                gap = $urandom_range(8, 30);
            else if (pick >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    task automatic feed_byte(input logic [7:0] b);
        put_byte(b, 1'b0, '0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_unit();
        logic [7:0]  hdr [HDR_BYTES];
        logic [31:0] len;
        logic [31:0] chan;
        logic [7:0]  kind;
        logic [31:0] cap;
        flaw_t       flaw;
        int          mode;
        int          count;
        int          k;
        mode = $urandom_range(0, 99);
        if (mode < 12)
        begin
            repeat ($urandom_range(1, 20)) feed_byte(8'($urandom));
            return;
        end
        kind = 8'($urandom_range(0, ph_max_kind));
        chan = $urandom;
        cap  = (ph_max_len < 12) ? ph_max_len : 32'd12;
        if (ph_max_len >= 40 && $urandom_range(0, 15) == 0)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(0, cap);
        flaw = FLAW_NONE;
        if (mode >= 78)
        begin
            flaw = flaw_t'($urandom_range(FLAW_MAGIC, FLAW_SHORT));
            if (flaw == FLAW_LENGTH && ph_max_len == 32'hFFFFFFFF)
                flaw = FLAW_MAGIC;
            if (flaw == FLAW_KIND && ph_max_kind == 8'hFF)
                flaw = FLAW_MAGIC;
            if (flaw == FLAW_SHORT && ph_max_len > 64)
                flaw = FLAW_MAGIC;
        end
        if (flaw == FLAW_LENGTH)
            len = ph_max_len + 1 + ($urandom % (32'hFFFFFFFF - ph_max_len));
        if (flaw == FLAW_KIND)
            kind = 8'($urandom_range(ph_max_kind + 1, 255));
        for (k = 0; k < 4; k++)
        begin
            hdr[k]     = ph_magic[8*k +: 8];
            hdr[4 + k] = len[8*k +: 8];
            hdr[9 + k] = chan[8*k +: 8];
        end
        hdr[8] = kind;
        if (flaw == FLAW_MAGIC)
        begin
            k = $urandom_range(0, 3);
            hdr[k] = hdr[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        count = (flaw == FLAW_SHORT) ? $urandom_range(1, HDR_BYTES - 1) : HDR_BYTES;
        for (k = 0; k < count; k++)
            feed_byte(hdr[k]);
        if (flaw == FLAW_NONE)
            repeat (len) feed_byte(8'($urandom));
    endtask

    initial
    begin
        int          ph;
        int          start;
        bit          held;
        logic [31:0] kind_word;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (intro_rows[i])
        begin
            if (intro_rows[i].kind == ROW_REG)
                write_reg(intro_rows[i].idx, intro_rows[i].data);
            else
                put_byte(intro_rows[i].data[7:0], intro_rows[i].typed, intro_rows[i].want);
        end

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    ph_magic    = 32'hD4C3B2A1;
                    ph_max_len  = 32'hFFFFFFFF;
                    ph_max_kind = 8'h3F;
                end
                1:
                begin
                    ph_magic    = 32'h00000000;
                    ph_max_len  = 32'h00000000;
                    ph_max_kind = 8'h00;
                end
                2:
                begin
                    ph_magic    = 32'hFFFFFFFF;
                    ph_max_len  = 32'd6;
                    ph_max_kind = 8'hFF;
                end
                default:
                begin
                    ph_magic    = $urandom;
                    ph_max_len  = $urandom_range(0, 20);
                    ph_max_kind = 8'($urandom_range(0, 255));
                end
            endcase
            kind_word = $urandom;
            kind_word[7:0] = ph_max_kind;
            write_reg(CFG_MAGIC, ph_magic);
            write_reg(CFG_MAX_LEN, ph_max_len);
            write_reg(CFG_MAX_KIND, kind_word);
            calm <= (ph == 2);
            start = bytes_sent;
            held  = (ph != 0 && ph != NUM_PHASES - 1);
            while (bytes_sent - start < PHASE_BYTES)
            begin
                if (!held && bytes_sent - start > 60)
                begin
                    hold_req <= hold_req + 1;
                    held = 1'b1;
                end
                send_unit();
            end
        end

        drain();
        if (mismatches == 0)
            $display("** magic_sync_frame_deframer_top: PASSED **");
        else
            $display("** magic_sync_frame_deframer_top: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/msfd_pkg.sv
hdl/msfd_cell.sv
hdl/msfd_out_skid.sv
hdl/magic_sync_frame_deframer_top.sv
test/tb_top.sv
